// ----- sv/capability_token_table_unit_macros.svh -----
// ----------------------------------------------------------------------------
// Capability token table unit - assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CAPABILITY_TOKEN_TABLE_UNIT_MACROS_SVH
`define CAPABILITY_TOKEN_TABLE_UNIT_MACROS_SVH

// Same-cycle implication.
`define CTT_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define CTT_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- sv/ctt_pkg.sv -----
// ----------------------------------------------------------------------------
// Capability token table package
// Sizes, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package ctt_pkg;

   localparam int TABLE_ENTRIES = 64;
   localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int KIND_W        = 3;
   localparam int STATUS_W      = 3;
   localparam int ID_W          = 32;
   localparam int CAP_W         = 32;
   localparam int ENTRY_W       = ID_W + CAP_W;

   localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(TABLE_ENTRIES - 1);
   localparam logic [CAP_W-1:0] SYSCALL_BIT = 32'h0000_0400;

   typedef enum logic [KIND_W-1:0] {
      KIND_CHECK      = 3'd0,
      KIND_DELEGATE   = 3'd1,
      KIND_REVOKE     = 3'd2,
      KIND_QUERY      = 3'd3,
      KIND_CREATE     = 3'd4,
      KIND_INVALIDATE = 3'd5
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK        = 3'd0,
      STAT_BAD_TOKEN = 3'd1,
      STAT_DENIED    = 3'd2,
      STAT_NO_SPACE  = 3'd3,
      STAT_BAD_OP    = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      FSM_IDLE   = 2'd0,
      FSM_SCAN   = 2'd1,
      FSM_DRAIN  = 2'd2,
      FSM_COMMIT = 2'd3
   } state_type;

   typedef struct packed {
      logic load;    // capture request, restart scan
      logic scan;    // issue table read, advance address
      logic commit;  // apply update, load response
   } cmd_type;

   typedef struct packed {
      logic scan_last;  // read address is at the last entry
      logic rsp_busy;   // response register holds a beat not yet taken
   } sts_type;

endpackage

// ----- sv/ctt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module ctt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                        clock,
   input  logic                                        we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                            wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                            rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- sv/ctt_ctrl.sv -----
// ----------------------------------------------------------------------------
// Capability token table controller
// Sequences accept, table scan, drain, and commit for one request at a time.
// ----------------------------------------------------------------------------
`include "capability_token_table_unit_macros.svh"

module ctt_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ctt_pkg::sts_type sts,
   output ctt_pkg::cmd_type cmd
);

   import ctt_pkg::*;

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FSM_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         FSM_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = FSM_SCAN;
            end
         end
         FSM_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_last) begin
               state_in = FSM_DRAIN;
            end
         end
         FSM_DRAIN: begin
            // last read data lands this cycle
            state_in = FSM_COMMIT;
         end
         FSM_COMMIT: begin
            if (!sts.rsp_busy) begin
               cmd.commit = 1'b1;
               state_in   = FSM_IDLE;
            end
         end
         default: begin
            state_in = FSM_IDLE;
         end
      endcase
   end

   `CTT_ASSERT_NXT(a_accept_starts_scan, (state_ff == FSM_IDLE) && req_valid, state_ff == FSM_SCAN, "accepted request did not start a scan")
   `CTT_ASSERT_NXT(a_scan_runs_to_end, (state_ff == FSM_SCAN) && !sts.scan_last, state_ff == FSM_SCAN, "scan left early")
   `CTT_ASSERT_NXT(a_drain_to_commit, state_ff == FSM_DRAIN, state_ff == FSM_COMMIT, "drain did not move to commit")

endmodule

// ----- sv/ctt_dp.sv -----
// ----------------------------------------------------------------------------
// Capability token table datapath
// Request registers, table RAM, scan match tracking, update and response.
// ----------------------------------------------------------------------------
`include "capability_token_table_unit_macros.svh"

module ctt_dp (
   input  logic                            clock,
   input  logic                            reset,
   input  ctt_pkg::cmd_type                cmd,
   output ctt_pkg::sts_type                sts,
   input  logic [ctt_pkg::KIND_W-1:0]      req_kind,
   input  logic [ctt_pkg::ID_W-1:0]        req_caller_token,
   input  logic [ctt_pkg::ID_W-1:0]        req_first_id,
   input  logic [ctt_pkg::ID_W-1:0]        req_second_id,
   input  logic [ctt_pkg::CAP_W-1:0]       req_cap_mask,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [ctt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [ctt_pkg::CAP_W-1:0]       rsp_caps
);

   import ctt_pkg::*;

   // request
   logic [KIND_W-1:0] kind_ff;
   logic [ID_W-1:0]   caller_ff, first_ff, second_ff;
   logic [CAP_W-1:0]  mask_ff;

   // scan
   logic [IDX_W-1:0]   addr_ff;
   logic [IDX_W-1:0]   rd_idx_ff;
   logic               rd_pend_ff;
   logic [ENTRY_W-1:0] rd_data;
   logic [ID_W-1:0]    rd_id;
   logic [CAP_W-1:0]   rd_caps;
   logic               rd_live;

   // match tracking
   logic             cl_hit_ff, cl_sys_ff;
   logic             s_hit_ff, t_hit_ff, f_hit_ff;
   logic [IDX_W-1:0] s_idx_ff, t_idx_ff, f_idx_ff;
   logic [CAP_W-1:0] s_caps_ff, t_caps_ff;

   // table valid marks
   logic [TABLE_ENTRIES-1:0] valid_ff, valid_in;

   // update
   logic               we;
   logic [IDX_W-1:0]   waddr;
   logic [ENTRY_W-1:0] wdata;
   status_type         status_in;
   logic [CAP_W-1:0]   caps_in;
   logic               priv_ok, holds_all;

   // response
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [CAP_W-1:0]    rsp_caps_ff;

   ctt_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock (clock),
      .we    (we),
      .waddr (waddr),
      .wdata (wdata),
      .raddr (addr_ff),
      .rdata (rd_data)
   );

   assign rd_id   = rd_data[ENTRY_W-1:CAP_W];
   assign rd_caps = rd_data[CAP_W-1:0];
   assign rd_live = valid_ff[rd_idx_ff];

   assign sts.scan_last = (addr_ff == LAST_IDX);
   assign sts.rsp_busy  = rsp_valid_ff && !rsp_ready;

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff   <= req_kind;
         caller_ff <= req_caller_token;
         first_ff  <= req_first_id;
         second_ff <= req_second_id;
         mask_ff   <= req_cap_mask;
      end
   end

   // scan address and read pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         rd_pend_ff <= cmd.scan;
         if (cmd.load) begin
            addr_ff <= '0;
         end else if (cmd.scan) begin
            addr_ff <= addr_ff + IDX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= addr_ff;
   end

   // keep the lowest-index match for each lookup
   always_ff @(posedge clock) begin
      if (reset || cmd.load) begin
         cl_hit_ff <= 1'b0;
         s_hit_ff  <= 1'b0;
         t_hit_ff  <= 1'b0;
         f_hit_ff  <= 1'b0;
      end else if (rd_pend_ff) begin
         if (rd_live && !cl_hit_ff && (rd_id == caller_ff)) begin
            cl_hit_ff <= 1'b1;
         end
         if (rd_live && !s_hit_ff && (rd_id == first_ff)) begin
            s_hit_ff <= 1'b1;
         end
         if (rd_live && !t_hit_ff && (rd_id == second_ff)) begin
            t_hit_ff <= 1'b1;
         end
         if (!rd_live && !f_hit_ff) begin
            f_hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rd_pend_ff) begin
         if (rd_live && !cl_hit_ff && (rd_id == caller_ff)) begin
            cl_sys_ff <= ((rd_caps & SYSCALL_BIT) == SYSCALL_BIT);
         end
         if (rd_live && !s_hit_ff && (rd_id == first_ff)) begin
            s_idx_ff  <= rd_idx_ff;
            s_caps_ff <= rd_caps;
         end
         if (rd_live && !t_hit_ff && (rd_id == second_ff)) begin
            t_idx_ff  <= rd_idx_ff;
            t_caps_ff <= rd_caps;
         end
         if (!rd_live && !f_hit_ff) begin
            f_idx_ff <= rd_idx_ff;
         end
      end
   end

   // resolve the request and form the table update
   assign priv_ok   = cl_hit_ff && cl_sys_ff;
   assign holds_all = ((s_caps_ff & mask_ff) == mask_ff);

   always_comb begin
      status_in = STAT_OK;
      caps_in   = '0;
      we        = 1'b0;
      waddr     = s_idx_ff;
      wdata     = {first_ff, s_caps_ff & ~mask_ff};
      valid_in  = valid_ff;
      case (kind_type'(kind_ff))
         KIND_CHECK: begin
            if (!s_hit_ff) begin
               status_in = STAT_BAD_TOKEN;
            end else if (!holds_all) begin
               status_in = STAT_DENIED;
            end
         end
         KIND_DELEGATE: begin
            if (!priv_ok) begin
               status_in = STAT_DENIED;
            end else if (!s_hit_ff || !t_hit_ff) begin
               status_in = STAT_BAD_TOKEN;
            end else if (!holds_all) begin
               status_in = STAT_DENIED;
            end else begin
               we    = cmd.commit;
               waddr = t_idx_ff;
               wdata = {second_ff, t_caps_ff | mask_ff};
            end
         end
         KIND_REVOKE: begin
            if (!priv_ok) begin
               status_in = STAT_DENIED;
            end else if (!s_hit_ff) begin
               status_in = STAT_BAD_TOKEN;
            end else begin
               we = cmd.commit;
            end
         end
         KIND_QUERY: begin
            if (!priv_ok) begin
               status_in = STAT_DENIED;
            end else if (!s_hit_ff) begin
               status_in = STAT_BAD_TOKEN;
            end else begin
               caps_in = s_caps_ff;
            end
         end
         KIND_CREATE: begin
            if (!f_hit_ff) begin
               status_in = STAT_NO_SPACE;
            end else begin
               we    = cmd.commit;
               waddr = f_idx_ff;
               wdata = {first_ff, mask_ff};
               if (cmd.commit) begin
                  valid_in[f_idx_ff] = 1'b1;
               end
            end
         end
         KIND_INVALIDATE: begin
            if (!s_hit_ff) begin
               status_in = STAT_BAD_TOKEN;
            end else if (cmd.commit) begin
               valid_in[s_idx_ff] = 1'b0;
            end
         end
         default: begin
            status_in = STAT_BAD_OP;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_in;
         rsp_caps_ff   <= caps_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_caps   = rsp_caps_ff;

   `CTT_ASSERT_NXT(a_commit_loads_rsp, cmd.commit, rsp_valid_ff, "commit did not present a response")
   `CTT_ASSERT_NXT(a_scan_read_pending, cmd.scan, rd_pend_ff, "scan read not tracked")
   `CTT_ASSERT_IMP(a_commit_rsp_free, cmd.commit, !sts.rsp_busy, "commit over a waiting response")

endmodule

// ----- sv/capability_token_table_unit.sv -----
// ----------------------------------------------------------------------------
// Capability token table unit
// Token table with check, delegate, revoke, query, create and invalidate.
// ----------------------------------------------------------------------------
// Each request beat on req_ walks the whole table (TABLE_ENTRIES entries of
// id and capability mask, held in one single-port-read RAM) one entry per
// cycle, catching the lowest valid match for the caller, first and second
// ids plus the lowest free slot in a single pass; one commit cycle then
// writes the update back and loads the response register. A request goes
// through the scan of every entry through the RAM read port, a drain state
// for the last read and the commit state; the next request is taken the
// cycle after commit. The response register holds its beat until
// rsp_ready, so a new request may be accepted and scanned while an older
// response waits; commit stalls only if that response is still not taken.
// Valid marks are flops cleared by reset, so no clearing pass is needed;
// ids and masks of never-written slots are never used. Delegate, revoke and
// query require the caller token to hold the syscall bit (0x0400); status
// codes are 0 ok, 1 invalid token, 2 access denied, 3 no space, 4 invalid op.
// ----------------------------------------------------------------------------
module capability_token_table_unit (
   input  logic                         clock,
   input  logic                         reset,
   // request channel
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [ctt_pkg::KIND_W-1:0]   req_kind,
   input  logic [ctt_pkg::ID_W-1:0]     req_caller_token,
   input  logic [ctt_pkg::ID_W-1:0]     req_first_id,
   input  logic [ctt_pkg::ID_W-1:0]     req_second_id,
   input  logic [ctt_pkg::CAP_W-1:0]    req_cap_mask,
   // response channel
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [ctt_pkg::STATUS_W-1:0] rsp_status,
   output logic [ctt_pkg::CAP_W-1:0]    rsp_caps
);

   import ctt_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence: accept, scan, drain last read, commit
   ctt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // table, match tracking, update and response register
   ctt_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_kind),
      .req_caller_token (req_caller_token),
      .req_first_id     (req_first_id),
      .req_second_id    (req_second_id),
      .req_cap_mask     (req_cap_mask),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_caps         (rsp_caps)
   );

endmodule
